FILE: rtl/weighted_lsq_gradient_coeffs_macros.svh
// Assertion macros for the gradient coefficient block.
`ifndef WEIGHTED_LSQ_GRADIENT_COEFFS_MACROS_SVH
`define WEIGHTED_LSQ_GRADIENT_COEFFS_MACROS_SVH

`ifndef SYNTHESIS
`define WLSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WLSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define WLSQ_ASSERT(lbl, prop, msg)
`define WLSQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/wlsq_pkg.sv
package wlsq_pkg;

    localparam int MAX_NEIGHBORS = 8;
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W         = (MAX_NEIGHBORS > 2) ? $clog2(MAX_NEIGHBORS) : 1;

    localparam int DIV_N_W   = 96;
    localparam int DIV_D_W   = 64;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [DIV_N_W-1:0] CAP_TERM = DIV_N_W'(1) << 40;
    localparam logic [DIV_N_W-1:0] CAP_S    = DIV_N_W'(1) << 62;
    localparam logic [DIV_N_W-1:0] CAP_M    = DIV_N_W'(1) << 32;

    localparam logic signed [63:0] DET_MIN = 64'sd4294967296;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MXX,
        S_MYY,
        S_MXY,
        S_DIV,
        S_DIVEND,
        S_LAST,
        S_DET1,
        S_DET2,
        S_DET3,
        S_DET4,
        S_FETCH,
        S_RX,
        S_RY,
        S_P1,
        S_P2,
        S_P3,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_XX,
        OP_YY,
        OP_XY,
        OP_S,
        OP_M
    } div_op_t;

endpackage

FILE: rtl/wlsq_offset_if.sv
interface wlsq_offset_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] dist_x;
    logic signed [23:0] dist_y;
    logic               last_offset;

    modport source (output valid, dist_x, dist_y, last_offset, input ready);
    modport sink   (input valid, dist_x, dist_y, last_offset, output ready);
endinterface

FILE: rtl/wlsq_coef_if.sv
interface wlsq_coef_if;
    logic               valid;
    logic               ready;
    logic [2:0]         neighbor_index;
    logic signed [31:0] coef_x;
    logic signed [31:0] coef_y;
    logic               degenerate;
    logic               last_coef;

    modport source (output valid, neighbor_index, coef_x, coef_y, degenerate, last_coef,
                    input ready);
    modport sink   (input valid, neighbor_index, coef_x, coef_y, degenerate, last_coef,
                    output ready);
endinterface

FILE: rtl/weighted_lsq_gradient_coeffs.sv
// Channel     Dir  Request contents
// offset_in   in   dist_x, dist_y (Q8.16), last_offset
// coef_out    out  neighbor_index, coef_x, coef_y (Q16.16), degenerate, last_coef
//
// One 32x32 multiplier and one radix-2 restoring divider are shared. Each offset
// runs three divisions; a zero or surplus offset runs none. After the marked
// offset the determinant is formed, then each neighbour takes two divisions per
// axis, or none on a degenerate cell.
// Reset clears count, sums and error flag; a stalled result holds in the output
// register while the next one is computed.
`include "weighted_lsq_gradient_coeffs_macros.svh"

module weighted_lsq_gradient_coeffs
(
    input  logic         clk,
    input  logic         rst_n,
    wlsq_offset_if.sink  offset_in,
    wlsq_coef_if.source  coef_out
);
    import wlsq_pkg::*;

    state_t state_reg, state_next;
    div_op_t op_reg, op_next;

    logic               axis_reg, axis_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic               bad_reg, bad_next;
    logic               last_reg, last_next;
    logic signed [23:0] dx_reg, dx_next;
    logic signed [23:0] dy_reg, dy_next;
    logic [47:0]        sqx_reg, sqx_next;
    logic [47:0]        sqy_reg, sqy_next;
    logic [47:0]        r2_reg, r2_next;
    logic signed [63:0] pa_reg, pa_next;
    logic signed [63:0] pb_reg, pb_next;
    logic signed [63:0] det_reg, det_next;
    logic signed [39:0] sxx_reg, sxx_next;
    logic signed [39:0] sxy_reg, sxy_next;
    logic signed [39:0] syy_reg, syy_next;
    logic               neg_reg, neg_next;
    logic [31:0]        cx_reg, cx_next;
    logic [31:0]        cy_reg, cy_next;

    logic [DIV_N_W-1:0]   div_n_reg, div_n_next;
    logic [DIV_D_W-1:0]   div_rem_reg, div_rem_next;
    logic [DIV_D_W-1:0]   div_d_reg, div_d_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_idx_reg, out_idx_next;
    logic [31:0]        out_cx_reg, out_cx_next;
    logic [31:0]        out_cy_reg, out_cy_next;
    logic               out_degen_reg, out_degen_next;
    logic               out_last_reg, out_last_next;

    logic signed [23:0] store_x [MAX_NEIGHBORS];
    logic signed [23:0] store_y [MAX_NEIGHBORS];
    logic signed [23:0] rd_x_reg, rd_y_reg;

    logic               in_acc;
    logic               in_zero;
    logic               full;
    logic               is_last_nb;
    logic               out_load;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [DIV_D_W:0]   div_trial;
    logic               div_bit;
    logic [DIV_N_W-1:0] div_cap;
    logic [DIV_N_W-1:0] div_q;
    logic signed [63:0] p_diff;
    logic [63:0]        p_mag;
    logic [63:0]        pxy_mag;
    logic [31:0]        coef_val;

    assign in_acc     = offset_in.valid && offset_in.ready;
    assign in_zero    = (offset_in.dist_x == 24'sd0) && (offset_in.dist_y == 24'sd0);
    assign full       = cnt_reg >= CNT_W'(MAX_NEIGHBORS);
    assign is_last_nb = CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1));
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || coef_out.ready);

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MXX:
            begin
                mul_a = 32'(dx_reg);
                mul_b = 32'(dx_reg);
            end
            S_MYY:
            begin
                mul_a = 32'(dy_reg);
                mul_b = 32'(dy_reg);
            end
            S_MXY:
            begin
                mul_a = 32'(dx_reg);
                mul_b = 32'(dy_reg);
            end
            S_DET1:
            begin
                mul_a = 32'(sxx_reg);
                mul_b = 32'(syy_reg);
            end
            S_DET2:
            begin
                mul_a = 32'(sxy_reg);
                mul_b = 32'(sxy_reg);
            end
            S_RX:
            begin
                mul_a = 32'(rd_x_reg);
                mul_b = 32'(rd_x_reg);
            end
            S_RY:
            begin
                mul_a = 32'(dy_reg);
                mul_b = 32'(dy_reg);
            end
            S_P1:
            begin
                mul_a = axis_reg ? 32'(sxx_reg) : 32'(syy_reg);
                mul_b = axis_reg ? 32'(dy_reg) : 32'(dx_reg);
            end
            S_P2:
            begin
                mul_a = 32'(sxy_reg);
                mul_b = axis_reg ? 32'(dx_reg) : 32'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider step and saturation
    assign div_trial = {div_rem_reg, div_n_reg[DIV_N_W-1]};
    assign div_bit   = div_trial >= {1'b0, div_d_reg};

    always_comb
    begin
        case (op_reg)
            OP_S:    div_cap = CAP_S;
            OP_M:    div_cap = CAP_M;
            default: div_cap = CAP_TERM;
        endcase
    end

    assign div_q   = (div_n_reg >= div_cap) ? div_cap : div_n_reg;
    assign p_diff  = pa_reg - pb_reg;
    assign p_mag   = p_diff[63] ? 64'(-p_diff) : 64'(p_diff);
    assign pxy_mag = pa_reg[63] ? 64'(-pa_reg) : 64'(pa_reg);

    always_comb
    begin
        if (neg_reg)
            coef_val = (div_q > DIV_N_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-div_q);
        else
            coef_val = (div_q > DIV_N_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = (full || in_zero) ? S_LAST : S_MXX;
            S_MXX:    state_next = S_MYY;
            S_MYY:    state_next = S_MXY;
            S_MXY:    state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                    state_next = S_DIVEND;
            S_DIVEND:
            begin
                case (op_reg)
                    OP_XY:   state_next = S_LAST;
                    OP_M:    state_next = axis_reg ? S_OUT : S_P1;
                    default: state_next = S_DIV;
                endcase
            end
            S_LAST:   state_next = last_reg ? S_DET1 : S_IDLE;
            S_DET1:   state_next = S_DET2;
            S_DET2:   state_next = S_DET3;
            S_DET3:   state_next = S_DET4;
            S_DET4:   state_next = S_FETCH;
            S_FETCH:  state_next = bad_reg ? S_OUT : S_RX;
            S_RX:     state_next = S_RY;
            S_RY:     state_next = S_P1;
            S_P1:     state_next = S_P2;
            S_P2:     state_next = S_P3;
            S_P3:     state_next = S_DIV;
            S_OUT:
                if (out_load)
                    state_next = is_last_nb ? S_IDLE : S_FETCH;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next      = op_reg;
        axis_next    = axis_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        bad_next     = bad_reg;
        last_next    = last_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        r2_next      = r2_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        det_next     = det_reg;
        sxx_next     = sxx_reg;
        sxy_next     = sxy_reg;
        syy_next     = syy_reg;
        neg_next     = neg_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        div_n_next   = div_n_reg;
        div_rem_next = div_rem_reg;
        div_d_next   = div_d_reg;
        div_cnt_next = div_cnt_reg;

        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    dx_next   = offset_in.dist_x;
                    dy_next   = offset_in.dist_y;
                    last_next = offset_in.last_offset;
                    if (full || in_zero)
                        err_next = 1'b1;
                    if (!full)
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            S_MXX: sqx_next = mul_p[47:0];
            S_MYY: sqy_next = mul_p[47:0];
            S_MXY:
            begin
                pa_next      = mul_p;
                r2_next      = sqx_reg + sqy_reg;
                op_next      = OP_XX;
                div_n_next   = DIV_N_W'(sqx_reg) << 24;
                div_d_next   = DIV_D_W'(sqx_reg + sqy_reg);
                div_rem_next = '0;
            end
            S_DIV:
            begin
                div_rem_next = div_bit ? DIV_D_W'(div_trial - {1'b0, div_d_reg})
                                       : div_trial[DIV_D_W-1:0];
                div_n_next   = {div_n_reg[DIV_N_W-2:0], div_bit};
                div_cnt_next = (div_cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                             ? '0 : div_cnt_reg + DIV_CNT_W'(1);
            end
            S_DIVEND:
            begin
                div_rem_next = '0;
                case (op_reg)
                    OP_XX:
                    begin
                        sxx_next   = sxx_reg + signed'(div_q[39:0]);
                        op_next    = OP_YY;
                        div_n_next = DIV_N_W'(sqy_reg) << 24;
                    end
                    OP_YY:
                    begin
                        syy_next   = syy_reg + signed'(div_q[39:0]);
                        op_next    = OP_XY;
                        div_n_next = DIV_N_W'(pxy_mag) << 24;
                    end
                    OP_XY:
                        sxy_next = pa_reg[63] ? sxy_reg - signed'(div_q[39:0])
                                              : sxy_reg + signed'(div_q[39:0]);
                    OP_S:
                    begin
                        op_next    = OP_M;
                        div_n_next = DIV_N_W'(div_q) << 24;
                        div_d_next = DIV_D_W'(det_reg);
                    end
                    default:
                    begin
                        if (axis_reg)
                            cy_next = coef_val;
                        else
                            cx_next = coef_val;
                        axis_next = 1'b1;
                    end
                endcase
            end
            S_DET1: pa_next = mul_p;
            S_DET2: pb_next = mul_p;
            S_DET3: det_next = p_diff;
            S_DET4:
            begin
                bad_next  = err_reg || (det_reg < DET_MIN);
                idx_next  = '0;
                axis_next = 1'b0;
            end
            S_RX:
            begin
                sqx_next = mul_p[47:0];
                dx_next  = rd_x_reg;
                dy_next  = rd_y_reg;
            end
            S_RY: sqy_next = mul_p[47:0];
            S_P1:
            begin
                r2_next = sqx_reg + sqy_reg;
                pa_next = mul_p;
            end
            S_P2: pb_next = mul_p;
            S_P3:
            begin
                op_next      = OP_S;
                neg_next     = p_diff[63];
                div_n_next   = DIV_N_W'(p_mag) << 32;
                div_d_next   = DIV_D_W'(r2_reg);
                div_rem_next = '0;
            end
            S_OUT:
                if (out_load)
                begin
                    axis_next = 1'b0;
                    if (is_last_nb)
                    begin
                        cnt_next = '0;
                        err_next = 1'b0;
                        sxx_next = '0;
                        sxy_next = '0;
                        syy_next = '0;
                    end
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        out_valid_next = out_valid_reg && !coef_out.ready;
        out_idx_next   = out_idx_reg;
        out_cx_next    = out_cx_reg;
        out_cy_next    = out_cy_reg;
        out_degen_next = out_degen_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = 3'(idx_reg);
            out_cx_next    = bad_reg ? '0 : cx_reg;
            out_cy_next    = bad_reg ? '0 : cy_reg;
            out_degen_next = bad_reg;
            out_last_next  = is_last_nb;
        end
    end

    assign offset_in.ready         = state_reg == S_IDLE;
    assign coef_out.valid          = out_valid_reg;
    assign coef_out.neighbor_index = out_idx_reg;
    assign coef_out.coef_x         = out_cx_reg;
    assign coef_out.coef_y         = out_cy_reg;
    assign coef_out.degenerate     = out_degen_reg;
    assign coef_out.last_coef      = out_last_reg;

    // offset store
    always_ff @(posedge clk)
    begin
        if (in_acc && !full)
        begin
            store_x[cnt_reg[IDX_W-1:0]] <= offset_in.dist_x;
            store_y[cnt_reg[IDX_W-1:0]] <= offset_in.dist_y;
        end
        rd_x_reg <= store_x[idx_reg];
        rd_y_reg <= store_y[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            sxx_reg       <= '0;
            sxy_reg       <= '0;
            syy_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            sxx_reg       <= sxx_next;
            sxy_reg       <= sxy_next;
            syy_reg       <= syy_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        axis_reg      <= axis_next;
        idx_reg       <= idx_next;
        bad_reg       <= bad_next;
        last_reg      <= last_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sqx_reg       <= sqx_next;
        sqy_reg       <= sqy_next;
        r2_reg        <= r2_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        det_reg       <= det_next;
        neg_reg       <= neg_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        div_n_reg     <= div_n_next;
        div_rem_reg   <= div_rem_next;
        div_d_reg     <= div_d_next;
        out_idx_reg   <= out_idx_next;
        out_cx_reg    <= out_cx_next;
        out_cy_reg    <= out_cy_next;
        out_degen_reg <= out_degen_next;
        out_last_reg  <= out_last_next;
    end

    `WLSQ_ASSERT_NEXT(a_busy_after_req, in_acc, state_reg != S_IDLE, "idle after request")
    `WLSQ_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_NEIGHBORS), "offset count overrun")
    `WLSQ_ASSERT(a_div_cnt, (div_cnt_reg != '0) |-> (state_reg == S_DIV), "divider count stray")
    `WLSQ_ASSERT(a_degen_zero, (out_valid_reg && out_degen_reg) |-> (out_cx_reg == '0 && out_cy_reg == '0), "degenerate result not zero")

endmodule
